@@ sv/assert_macros.svh @@
// assertion macros used by escape_time_iterator_top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ sv/esc_iter_pkg.sv @@
// types and constants for the escape time iterator
// no dependencies
`timescale 1ns / 1ps

package esc_iter_pkg;

   typedef struct packed {
      logic signed [63:0] point_real;
      logic signed [63:0] point_imag;
   } req_item_type;

   typedef struct packed {
      logic [15:0] iteration_count;
      logic        escaped;
      logic [62:0] magnitude_sq;
   } rsp_item_type;

   localparam int unsigned CSR_ADDR_WIDTH = 6;

   localparam logic [2:0] REG_MAX_ITER     = 3'd0;
   localparam logic [2:0] REG_MIN_ITER     = 3'd1;
   localparam logic [2:0] REG_JULIA_MODE   = 3'd2;
   localparam logic [2:0] REG_JULIA_C_REAL = 3'd3;
   localparam logic [2:0] REG_JULIA_C_IMAG = 3'd4;

   localparam logic [15:0] MAX_ITER_RESET = 16'd800;

   localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

endpackage

@@ sv/escape_time_iterator_top.sv @@
// escape time iterator, z = z*z + c in signed fixed point, one shared 32x32 multiplier
// depends on esc_iter_pkg and assert_macros.svh
//
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+----------------------------------
// request  | start, busy, req_item                   | taken when start and not busy
// response | rsp_strobe, rsp_item                    | one cycle strobe, no back pressure
// config   | psel, penable, pwrite, paddr, pwdata,   | apb write on access cycle,
//          | prdata, pready                          | pready tied high, 64-bit data bus
//
// one iteration runs 12 partial products through the single 32x32 multiplier, converting
// each product as its sum completes, then sums and the escape test
// a zero limit gives its result in the next cycle
// synchronous active-high reset clears control state and resets the config registers (max_iter to 800)
// busy is high while an item iterates, never for a zero-limit item; results are never held off
`timescale 1ns / 1ps

`include "assert_macros.svh"

module escape_time_iterator_top #(
   parameter int FRAC_BITS   = 56,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  esc_iter_pkg::req_item_type                req_item,
   output logic                                      rsp_strobe,
   output esc_iter_pkg::rsp_item_type                rsp_item,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [esc_iter_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [63:0]                               pwdata,
   output logic [63:0]                               prdata,
   output logic                                      pready
);

   import esc_iter_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [4:0] STEP_ABS     = 5'd0;
   localparam logic [4:0] STEP_MUL_LO  = 5'd1;
   localparam logic [4:0] STEP_MUL_HI  = 5'd12;
   localparam logic [4:0] STEP_ACC_LO  = 5'd2;
   localparam logic [4:0] STEP_ACC_HI  = 5'd13;
   localparam logic [4:0] STEP_CONV_XX = 5'd6;
   localparam logic [4:0] STEP_CONV_YY = 5'd10;
   localparam logic [4:0] STEP_CONV_XY = 5'd14;
   localparam logic [4:0] STEP_SUM     = 5'd15;
   localparam logic [4:0] STEP_NEXT    = 5'd16;

   localparam logic [1:0] PROD_XX = 2'd0;
   localparam logic [1:0] PROD_YY = 2'd1;

   localparam logic signed [63:0] ESC_BOUND = 64'(64'd4 << FRAC_BITS);

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? SAT_MIN : SAT_MAX;
      end
      return s;
   endfunction

   function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         return a[63] ? SAT_MIN : SAT_MAX;
      end
      return s;
   endfunction

   // config registers
   logic [15:0]        max_iter_ff, max_iter_in;
   logic [15:0]        min_iter_ff, min_iter_in;
   logic               julia_mode_ff, julia_mode_in;
   logic signed [63:0] julia_c_real_ff, julia_c_real_in;
   logic signed [63:0] julia_c_imag_ff, julia_c_imag_in;

   // control
   logic                   state_ff, state_in;
   logic [4:0]             step_ff, step_in;
   logic [COUNT_WIDTH-1:0] k_ff, k_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   // datapath
   logic signed [63:0] zx_ff, zx_in;
   logic signed [63:0] zy_ff, zy_in;
   logic signed [63:0] cx_ff, cx_in;
   logic signed [63:0] cy_ff, cy_in;
   logic [63:0]        ax_ff, ax_in;
   logic [63:0]        ay_ff, ay_in;
   logic               xy_neg_ff, xy_neg_in;
   logic [63:0]        mul_ff, mul_in;
   logic [127:0]       acc_ff, acc_in;
   logic signed [63:0] xx_ff, xx_in;
   logic signed [63:0] yy_ff, yy_in;
   logic signed [63:0] xy_ff, xy_in;
   logic signed [63:0] mag_ff, mag_in;
   logic signed [63:0] diff_ff, diff_in;

   logic                   cfg_write;
   logic                   accept;
   logic [3:0]             mul_idx;
   logic [3:0]             acc_idx;
   logic [63:0]            mul_a;
   logic [63:0]            mul_b;
   logic [31:0]            mul_a_half;
   logic [31:0]            mul_b_half;
   logic [127:0]           acc_addend;
   logic [127:0]           acc_base;
   logic [127:0]           conv_q;
   logic                   conv_neg;
   logic signed [63:0]     conv_val;
   logic [COUNT_WIDTH-1:0] limit;
   logic                   at_min;
   logic                   escape_now;

   assign cfg_write = psel & penable & pwrite;
   assign accept    = start & ~busy;
   assign limit     = COUNT_WIDTH'(32'(max_iter_ff));
   assign mul_idx   = 4'(step_ff - STEP_MUL_LO);
   assign acc_idx   = 4'(step_ff - STEP_ACC_LO);

   // multiplier operand selection
   always_comb begin
      unique case (mul_idx[3:2])
         PROD_XX: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         PROD_YY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         default: begin
            mul_a = ax_ff;
            mul_b = ay_ff;
         end
      endcase
      mul_a_half = mul_idx[1] ? mul_a[63:32] : mul_a[31:0];
      mul_b_half = mul_idx[0] ? mul_b[63:32] : mul_b[31:0];
   end

   // partial product alignment
   always_comb begin
      unique case (acc_idx[1:0])
         2'd0:    acc_addend = {64'd0, mul_ff};
         2'd3:    acc_addend = {mul_ff, 64'd0};
         default: acc_addend = {32'd0, mul_ff, 32'd0};
      endcase
      acc_base = (acc_idx[1:0] == 2'd0) ? 128'd0 : acc_ff;
   end

   // product scaling and saturation
   always_comb begin
      conv_q   = (step_ff == STEP_CONV_XY) ? (acc_ff >> (FRAC_BITS - 1)) : (acc_ff >> FRAC_BITS);
      conv_neg = (step_ff == STEP_CONV_XY) & xy_neg_ff;
      if (conv_q[127:63] != '0) begin
         conv_val = conv_neg ? SAT_MIN : SAT_MAX;
      end else begin
         conv_val = conv_neg ? -$signed(conv_q[63:0]) : $signed(conv_q[63:0]);
      end
   end

   assign at_min     = 32'(k_ff) >= 32'(min_iter_ff);
   assign escape_now = at_min && (mag_ff >= ESC_BOUND);

   always_comb begin
      max_iter_in     = max_iter_ff;
      min_iter_in     = min_iter_ff;
      julia_mode_in   = julia_mode_ff;
      julia_c_real_in = julia_c_real_ff;
      julia_c_imag_in = julia_c_imag_ff;
      state_in        = state_ff;
      step_in         = step_ff;
      k_in            = k_ff;
      rsp_strobe_in   = 1'b0;
      rsp_item_in     = rsp_item_ff;
      zx_in           = zx_ff;
      zy_in           = zy_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      ax_in           = ax_ff;
      ay_in           = ay_ff;
      xy_neg_in       = xy_neg_ff;
      mul_in          = mul_ff;
      acc_in          = acc_ff;
      xx_in           = xx_ff;
      yy_in           = yy_ff;
      xy_in           = xy_ff;
      mag_in          = mag_ff;
      diff_in         = diff_ff;

      if (cfg_write) begin
         unique case (paddr[5:3])
            REG_MAX_ITER:     max_iter_in     = pwdata[15:0];
            REG_MIN_ITER:     min_iter_in     = pwdata[15:0];
            REG_JULIA_MODE:   julia_mode_in   = pwdata[0];
            REG_JULIA_C_REAL: julia_c_real_in = pwdata;
            REG_JULIA_C_IMAG: julia_c_imag_in = pwdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in    = '0;
               step_in = STEP_ABS;
               mag_in  = '0;
               if (julia_mode_ff) begin
                  zx_in = req_item.point_real;
                  zy_in = req_item.point_imag;
                  cx_in = julia_c_real_ff;
                  cy_in = julia_c_imag_ff;
               end else begin
                  zx_in = '0;
                  zy_in = '0;
                  cx_in = req_item.point_real;
                  cy_in = req_item.point_imag;
               end
               if (limit == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = '0;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            step_in = 5'(step_ff + 5'd1);
            if (step_ff == STEP_ABS) begin
               ax_in     = zx_ff[63] ? 64'(-zx_ff) : 64'(zx_ff);
               ay_in     = zy_ff[63] ? 64'(-zy_ff) : 64'(zy_ff);
               xy_neg_in = zx_ff[63] ^ zy_ff[63];
            end
            if (step_ff >= STEP_MUL_LO && step_ff <= STEP_MUL_HI) begin
               mul_in = 64'(mul_a_half) * 64'(mul_b_half);
            end
            if (step_ff >= STEP_ACC_LO && step_ff <= STEP_ACC_HI) begin
               acc_in = acc_base + acc_addend;
            end
            if (step_ff == STEP_CONV_XX) begin
               xx_in = conv_val;
            end
            if (step_ff == STEP_CONV_YY) begin
               yy_in = conv_val;
            end
            if (step_ff == STEP_CONV_XY) begin
               xy_in = conv_val;
            end
            if (step_ff == STEP_SUM) begin
               mag_in  = add_sat(xx_ff, yy_ff);
               diff_in = sub_sat(xx_ff, yy_ff);
               zy_in   = add_sat(xy_ff, cy_ff);
            end
            if (step_ff == STEP_NEXT) begin
               zx_in   = add_sat(diff_ff, cx_ff);
               step_in = STEP_ABS;
               if (escape_now) begin
                  state_in                     = ST_IDLE;
                  rsp_strobe_in                = 1'b1;
                  rsp_item_in.iteration_count  = 16'(32'(k_ff));
                  rsp_item_in.escaped          = 1'b1;
                  rsp_item_in.magnitude_sq     = mag_ff[62:0];
               end else if (k_ff == COUNT_WIDTH'(limit - 1'b1)) begin
                  state_in                     = ST_IDLE;
                  rsp_strobe_in                = 1'b1;
                  rsp_item_in.iteration_count  = 16'(32'(limit));
                  rsp_item_in.escaped          = 1'b0;
                  rsp_item_in.magnitude_sq     = mag_ff[62:0];
               end else begin
                  k_in = COUNT_WIDTH'(k_ff + 1'b1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff     <= MAX_ITER_RESET;
         min_iter_ff     <= '0;
         julia_mode_ff   <= 1'b0;
         julia_c_real_ff <= '0;
         julia_c_imag_ff <= '0;
         state_ff        <= ST_IDLE;
         step_ff         <= STEP_ABS;
         k_ff            <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         max_iter_ff     <= max_iter_in;
         min_iter_ff     <= min_iter_in;
         julia_mode_ff   <= julia_mode_in;
         julia_c_real_ff <= julia_c_real_in;
         julia_c_imag_ff <= julia_c_imag_in;
         state_ff        <= state_in;
         step_ff         <= step_in;
         k_ff            <= k_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      zx_ff       <= zx_in;
      zy_ff       <= zy_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      xy_neg_ff   <= xy_neg_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      xy_ff       <= xy_in;
      mag_ff      <= mag_in;
      diff_ff     <= diff_in;
   end

   // register read back
   always_comb begin
      unique case (paddr[5:3])
         REG_MAX_ITER:     prdata = {48'd0, max_iter_ff};
         REG_MIN_ITER:     prdata = {48'd0, min_iter_ff};
         REG_JULIA_MODE:   prdata = {63'd0, julia_mode_ff};
         REG_JULIA_C_REAL: prdata = julia_c_real_ff;
         REG_JULIA_C_IMAG: prdata = julia_c_imag_ff;
         default:          prdata = '0;
      endcase
   end

   assign busy       = (state_ff == ST_RUN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;
   assign pready     = 1'b1;

   `ASSERT_NEXT(a_accept_runs, clock, reset, start && !busy, busy || rsp_strobe)
   `ASSERT_SAME(a_escape_bound, clock, reset, rsp_strobe && rsp_item.escaped,
                rsp_item.magnitude_sq >= ESC_BOUND[62:0])
   `ASSERT_SAME(a_step_range, clock, reset, busy, step_ff <= STEP_NEXT)

endmodule
